// ----- hdl/spa_pkg.sv -----
package spa_pkg;

    // List depth and the cap on results of one run
    localparam int MAX_TERMS   = 16;
    localparam int MAX_RESULTS = 32;

    // Entry address, list count (holds MAX_TERMS itself) and result counter widths
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int KW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    // Command codes
    localparam logic [1:0] CMD_APPEND_A = 2'd0;
    localparam logic [1:0] CMD_APPEND_B = 2'd1;
    localparam logic [1:0] CMD_RUN      = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]          command;
        logic signed [15:0]  coeff_in;
        logic [15:0]         exp_in;
    } t_in;

    // Result item
    typedef struct packed {
        logic signed [16:0]  coeff_out;
        logic [15:0]         exp_out;
        logic                term_valid;
        logic                last_term;
        logic                dropped_flag;
    } t_out;

    // One stored term
    typedef struct packed {
        logic signed [15:0]  coeff;
        logic [15:0]         exp;
    } t_term;

    // List state handed to the merge engine
    typedef struct packed {
        logic [CW-1:0]       cnt_a;
        logic [CW-1:0]       cnt_b;
        logic                sticky;
    } t_run_ctx;

endpackage

// ----- hdl/spa_list_ram.sv -----
module spa_list_ram (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [spa_pkg::AW-1:0] i_waddr,
    input  spa_pkg::t_term     i_wdata,
    input  logic [spa_pkg::AW-1:0] i_raddr,
    output spa_pkg::t_term     o_rdata
);
    import spa_pkg::*;

    t_term r_mem [MAX_TERMS];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/spa_merge.sv -----
module spa_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_run,
    input  spa_pkg::t_run_ctx  i_ctx,
    input  spa_pkg::t_term     i_rdata_a,
    input  spa_pkg::t_term     i_rdata_b,
    output logic [spa_pkg::AW-1:0] o_raddr_a,
    output logic [spa_pkg::AW-1:0] o_raddr_b,
    output logic               o_busy,
    output logic               o_done,
    output logic               o_strobe,
    output spa_pkg::t_out      o_result
);
    import spa_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [CW-1:0] r_cnt_a, r_cnt_b;
    logic [KW-1:0] r_k;
    logic          r_sticky;
    logic          r_strobe, n_strobe;
    t_out          r_result, n_result;

    logic          have_a, have_b, take_a, take_b, take_ab, more, last;
    logic          empty_run;

    // Pick the larger exponent, or both on a tie
    always_comb begin
        have_a  = (r_i < r_cnt_a);
        have_b  = (r_j < r_cnt_b);
        take_ab = have_a && have_b && (i_rdata_a.exp == i_rdata_b.exp);
        take_a  = have_a && (!have_b || (i_rdata_a.exp > i_rdata_b.exp));
        take_b  = have_b && (!have_a || (i_rdata_b.exp > i_rdata_a.exp));
    end

    // Next pointers, end-of-run detection and the result word
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_strobe  = 1'b0;
        n_result  = r_result;
        more      = 1'b0;
        last      = 1'b0;
        empty_run = (i_ctx.cnt_a == '0) && (i_ctx.cnt_b == '0);
        o_done    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_i = '0;
                n_j = '0;
                if (i_run) begin
                    if (empty_run) begin
                        // Nothing loaded: one empty result
                        n_strobe               = 1'b1;
                        n_result.coeff_out     = '0;
                        n_result.exp_out       = '0;
                        n_result.term_valid    = 1'b0;
                        n_result.last_term     = 1'b1;
                        n_result.dropped_flag  = i_ctx.sticky;
                        o_done                 = 1'b1;
                    end else begin
                        n_state = ST_MERGE;
                    end
                end
            end
            ST_MERGE: begin
                n_i  = r_i + CW'(take_a || take_ab);
                n_j  = r_j + CW'(take_b || take_ab);
                more = (n_i < r_cnt_a) || (n_j < r_cnt_b);
                last = !more || (r_k == KW'(MAX_RESULTS - 1));
                n_strobe              = 1'b1;
                n_result.term_valid   = 1'b1;
                n_result.last_term    = last;
                n_result.dropped_flag = r_sticky;
                if (take_ab) begin
                    n_result.coeff_out = 17'(i_rdata_a.coeff) + 17'(i_rdata_b.coeff);
                    n_result.exp_out   = i_rdata_a.exp;
                end else if (take_a) begin
                    n_result.coeff_out = 17'(i_rdata_a.coeff);
                    n_result.exp_out   = i_rdata_a.exp;
                end else begin
                    n_result.coeff_out = 17'(i_rdata_b.coeff);
                    n_result.exp_out   = i_rdata_b.exp;
                end
                if (last) begin
                    n_state = ST_IDLE;
                    o_done  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Read ahead: the RAMs fetch the entries the next cycle will compare
    assign o_raddr_a = n_i[AW-1:0];
    assign o_raddr_b = n_j[AW-1:0];

    // State, pointers, result count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_strobe <= n_strobe;
            if (r_state == ST_MERGE) begin
                r_k <= r_k + KW'(1);
            end else begin
                r_k <= '0;
            end
        end
    end

    // Registered result word, and snapshot of list state at run start
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (r_state == ST_IDLE) begin
            r_cnt_a  <= i_ctx.cnt_a;
            r_cnt_b  <= i_ctx.cnt_b;
            r_sticky <= i_ctx.sticky;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- hdl/sparse_polynomial_add.sv -----
// Channel   Ports                       Transfer
// -------   -------------------------   ---------------------------------------
// item in   start, busy, i_item         start high and busy low at clock edge
// result    o_strobe, o_result          o_strobe high for one cycle, no stall
//
// An append leaves busy low; a term for a non-full list is written to its
// list RAM at the accepting edge. A run with terms holds busy high and gives
// one merged term per cycle, paced by the registered read of the two list
// RAMs, read ahead at the next pointers; the first term passes the state and
// result registers, the last one while busy is low again. An empty run never
// raises busy; its result shows in the cycle right after the accepting edge.
// Reset (synchronous, active low) empties both lists and clears the drop
// flag; RAM contents are not cleared. Results cannot be held off.
module sparse_polynomial_add (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  spa_pkg::t_in    i_item,
    output logic            o_strobe,
    output spa_pkg::t_out   o_result
);
    import spa_pkg::*;

    logic [CW-1:0] r_cnt_a, r_cnt_b;
    logic          r_sticky;
    logic          accept, app_a, app_b, full_a, full_b, we_a, we_b, run, done;
    t_term         wterm, rdata_a, rdata_b;
    logic [AW-1:0] raddr_a, raddr_b;
    t_run_ctx      ctx;

    // Command decode
    assign accept = start && !busy;
    assign app_a  = accept && (i_item.command == CMD_APPEND_A);
    assign app_b  = accept && (i_item.command == CMD_APPEND_B);
    assign run    = accept && (i_item.command == CMD_RUN);
    assign full_a = (r_cnt_a >= CW'(MAX_TERMS));
    assign full_b = (r_cnt_b >= CW'(MAX_TERMS));
    assign we_a   = app_a && !full_a;
    assign we_b   = app_b && !full_b;

    assign wterm.coeff = i_item.coeff_in;
    assign wterm.exp   = i_item.exp_in;

    // List fill counts and drop flag; a finished run empties both lists
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_sticky <= 1'b0;
        end else if (done) begin
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_sticky <= 1'b0;
        end else begin
            if (we_a) begin
                r_cnt_a <= r_cnt_a + CW'(1);
            end
            if (we_b) begin
                r_cnt_b <= r_cnt_b + CW'(1);
            end
            if ((app_a && full_a) || (app_b && full_b)) begin
                r_sticky <= 1'b1;
            end
        end
    end

    assign ctx.cnt_a  = r_cnt_a;
    assign ctx.cnt_b  = r_cnt_b;
    assign ctx.sticky = r_sticky;

    spa_list_ram u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (wterm),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    spa_list_ram u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (wterm),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    spa_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_run     (run),
        .i_ctx     (ctx),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .o_busy    (busy),
        .o_done    (done),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

// ----- hdl/spa_checker.sv -----
module spa_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  spa_pkg::t_in    i_item,
    input  logic            o_strobe,
    input  spa_pkg::t_out   o_result
);
    import spa_pkg::*;

    // Reset leaves the block idle with no result pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("block not quiet after reset");

    // An empty result is always the only result of its run
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.term_valid |-> o_result.last_term)
        else $error("empty result without last_term");

    // Non-final terms only come out while the merge is running
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_term |-> busy)
        else $error("non-final term while idle");

    // The merge ends exactly with the final term
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe && o_result.last_term)
        else $error("merge ended without final term");

    // A run either starts the merge or gives the single empty result
    a_run_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.command == CMD_RUN)
        |=> busy || (o_strobe && o_result.last_term && !o_result.term_valid))
        else $error("run transfer got no response");

endmodule

bind sparse_polynomial_add spa_checker u_spa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
